/* src/rgb_to_ansi_color_stream_defines.svh */
// Assertion macros for the RGB to terminal colour quantiser.
// Taken in by every RTL file that carries concurrent checks.
`ifndef RGB_TO_ANSI_COLOR_STREAM_DEFINES_SVH
`define RGB_TO_ANSI_COLOR_STREAM_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define RTAC_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("rtac: same-cycle check failed");

// Consequent in the cycle after the antecedent.
`define RTAC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("rtac: next-cycle check failed");

`endif

/* src/rtac_pkg.sv */
// Shared types, codes and colour functions of the terminal colour quantiser.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package rtac_pkg;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       overlay_present;
        logic [7:0] overlay_alpha;
        logic [7:0] overlay_red;
        logic [7:0] overlay_green;
        logic [7:0] overlay_blue;
        logic       frame_first;
        logic       row_last;
        logic       frame_last;
    } px_t;

    typedef struct packed {
        logic       home_cursor;
        logic [1:0] colour_action;
        logic [7:0] palette_index;
        logic [7:0] true_red;
        logic [7:0] true_green;
        logic [7:0] true_blue;
        logic [7:0] glyph;
        logic [1:0] row_ending;
        logic       frame_done;
    } cmd_t;

    // Classified cell, front to back
    typedef struct packed {
        logic        first;
        logic        last;
        logic        row_last;
        logic [1:0]  kind;
        logic [7:0]  index;
        logic [23:0] rgb;
    } cls_t;

    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_BACKGROUND = 2'd1;
    localparam logic [1:0] ACT_PALETTE    = 2'd2;
    localparam logic [1:0] ACT_TRUE       = 2'd3;

    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_GRAY    = 2'd1;
    localparam logic [1:0] MODE_TRUE    = 2'd2;

    localparam logic [1:0] END_NONE       = 2'd0;
    localparam logic [1:0] END_CRLF       = 2'd1;
    localparam logic [1:0] END_ATTR_RESET = 2'd2;

    localparam logic REG_RENDER_MODE = 1'b0;
    localparam logic REG_CELL_GLYPH  = 1'b1;

    localparam logic [7:0] GLYPH_SPACE = 8'd32;
    localparam logic [7:0] FULL_ALPHA  = 8'd255;

    localparam logic [15:0] LUMA_R = 16'd77;
    localparam logic [15:0] LUMA_G = 16'd150;
    localparam logic [15:0] LUMA_B = 16'd29;

    localparam logic [7:0] IDX_BLACK     = 8'd16;
    localparam logic [7:0] IDX_WHITE     = 8'd231;
    localparam logic [7:0] IDX_GRAY_BASE = 8'd232;
    localparam logic [7:0] GRAY_LOW      = 8'd8;
    localparam logic [7:0] GRAY_HIGH     = 8'd248;
    localparam logic [7:0] CUBE_R_STEP   = 8'd36;
    localparam logic [7:0] CUBE_G_STEP   = 8'd6;
    localparam logic [15:0] RECIP_TEN    = 16'd205;  // x/10 == (x*205)>>11 for x < 1029

    // c5*255/31 for each 5-bit level
    localparam logic [7:0] C8_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // x/255 for x <= 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [7:0] gray_ramp(input logic [7:0] v);
        logic [15:0] m;
        m = 16'(v - GRAY_LOW) * RECIP_TEN;
        if (v < GRAY_LOW)
            return IDX_BLACK;
        else if (v >= GRAY_HIGH)
            return IDX_WHITE;
        else
            return IDX_GRAY_BASE + 8'(m[15:11]);
    endfunction

    // floor(c8*5/255)
    function automatic logic [7:0] cube_level(input logic [7:0] c8);
        if (c8 == 8'd255)      return 8'd5;
        else if (c8 >= 8'd204) return 8'd4;
        else if (c8 >= 8'd153) return 8'd3;
        else if (c8 >= 8'd102) return 8'd2;
        else if (c8 >= 8'd51)  return 8'd1;
        else                   return 8'd0;
    endfunction

    function automatic logic [7:0] palette_of(input logic [23:0] rgb);
        logic [7:0] r8, g8, b8;
        r8 = C8_LUT[rgb[23:19]];
        g8 = C8_LUT[rgb[15:11]];
        b8 = C8_LUT[rgb[7:3]];
        if (rgb[23:19] == rgb[15:11] && rgb[15:11] == rgb[7:3])
            return gray_ramp(r8);
        else
            return IDX_BLACK + cube_level(r8) * CUBE_R_STEP
                 + cube_level(g8) * CUBE_G_STEP + cube_level(b8);
    endfunction

    function automatic logic [7:0] gray_of(input logic [23:0] rgb);
        logic [15:0] y;
        y = 16'(rgb[23:16]) * LUMA_R + 16'(rgb[15:8]) * LUMA_G + 16'(rgb[7:0]) * LUMA_B;
        return gray_ramp(y[15:8]);
    endfunction

endpackage

`default_nettype wire

/* src/rtac_front.sv */
// Front end: takes pixels, blends the overlay, classifies the colour.
// Uses rtac_pkg; pushes into rtac_queue against a credit count.
`default_nettype none
`include "rgb_to_ansi_color_stream_defines.svh"

module rtac_front #(
    parameter int DEPTH = 4,
    parameter int CNT_W = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             px_valid,
    output logic                  px_stall,
    input  wire rtac_pkg::px_t    px,
    input  wire logic [1:0]       mode,
    input  wire logic [CNT_W-1:0] count,
    output logic                  push,
    output rtac_pkg::cls_t        push_data
);

    logic              v1_reg, v2_reg;
    logic [15:0]       sum_r_reg, sum_g_reg, sum_b_reg;
    logic              first1_reg, last1_reg, row1_reg;
    logic [23:0]       rgb2_reg;
    logic              first2_reg, last2_reg, row2_reg;
    logic [CNT_W:0]    inflight;
    logic              accept;
    logic [7:0]        alpha_eff;
    logic [7:0]        alpha_inv;

    // Items in the two stages hold a queue slot in advance
    assign inflight = (CNT_W+1)'(v1_reg) + (CNT_W+1)'(v2_reg) + (CNT_W+1)'(count);
    assign px_stall = inflight >= (CNT_W+1)'(DEPTH);
    assign accept   = px_valid && !px_stall;

    // Zero alpha reduces the blend to the plain pixel
    assign alpha_eff = (px.overlay_present && px.overlay_alpha != 8'd0) ? px.overlay_alpha
                                                                          : 8'd0;
    assign alpha_inv = rtac_pkg::FULL_ALPHA - alpha_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_r_reg  <= 16'(px.overlay_red) * 16'(alpha_eff)
                    + 16'(px.pixel_red) * 16'(alpha_inv);
        sum_g_reg  <= 16'(px.overlay_green) * 16'(alpha_eff)
                    + 16'(px.pixel_green) * 16'(alpha_inv);
        sum_b_reg  <= 16'(px.overlay_blue) * 16'(alpha_eff)
                    + 16'(px.pixel_blue) * 16'(alpha_inv);
        first1_reg <= px.frame_first;
        last1_reg  <= px.frame_last;
        row1_reg   <= px.row_last;
        rgb2_reg   <= {rtac_pkg::div255(sum_r_reg), rtac_pkg::div255(sum_g_reg),
                       rtac_pkg::div255(sum_b_reg)};
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        row2_reg   <= row1_reg;
    end

    always_comb
    begin
        push_data.first    = first2_reg;
        push_data.last     = last2_reg;
        push_data.row_last = row2_reg;
        push_data.rgb      = rgb2_reg;
        if (mode == rtac_pkg::MODE_GRAY)
            push_data.index = rtac_pkg::gray_of(rgb2_reg);
        else
            push_data.index = rtac_pkg::palette_of(rgb2_reg);
        if (rgb2_reg == 24'd0)
            push_data.kind = rtac_pkg::ACT_BACKGROUND;
        else if (mode == rtac_pkg::MODE_TRUE)
            push_data.kind = rtac_pkg::ACT_TRUE;
        else
            push_data.kind = rtac_pkg::ACT_PALETTE;
    end

    assign push = v2_reg;

endmodule

`default_nettype wire

/* src/rtac_queue.sv */
// Short queue between the front and back ends of the colour quantiser.
// Uses rtac_pkg for the entry type and the shared assertion macros.
`default_nettype none
`include "rgb_to_ansi_color_stream_defines.svh"

module rtac_queue #(
    parameter int DEPTH = 4,
    parameter int CNT_W = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rtac_pkg::cls_t   push_data,
    input  wire logic             pop,
    output rtac_pkg::cls_t        head,
    output logic                  nonempty,
    output logic [CNT_W-1:0]      count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rtac_pkg::cls_t     store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_data;
    end

    assign head     = store[rd_ptr_reg];
    assign nonempty = count_reg != '0;
    assign count    = count_reg;

    `RTAC_ASSERT_SAME(a_q_no_overflow, clk, rst_n, push, count_reg < CNT_W'(DEPTH))
    `RTAC_ASSERT_SAME(a_q_no_underflow, clk, rst_n, pop, count_reg != '0)

endmodule

`default_nettype wire

/* src/rtac_back.sv */
// Back end: suppresses repeated colour commands and builds the result.
// Uses rtac_pkg; pops rtac_queue into a single output register.
`default_nettype none
`include "rgb_to_ansi_color_stream_defines.svh"

module rtac_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rtac_pkg::cls_t   head,
    input  wire logic             nonempty,
    output logic                  pop,
    input  wire logic [7:0]       cell_glyph,
    output logic                  cmd_valid,
    input  wire logic             cmd_stall,
    output rtac_pkg::cmd_t        cmd
);

    logic             out_valid_reg;
    rtac_pkg::cmd_t   out_reg, out_next;
    logic [1:0]       prev_kind_reg, prev_kind_next;
    logic [7:0]       prev_index_reg, prev_index_next;
    logic [23:0]      prev_rgb_reg, prev_rgb_next;
    logic [1:0]       kind_seen;
    logic             issue;

    assign pop = nonempty && (!out_valid_reg || !cmd_stall);

    always_comb
    begin
        // Frame start forgets the remembered colour before deciding
        kind_seen = head.first ? rtac_pkg::ACT_NONE : prev_kind_reg;
        case (head.kind)
            rtac_pkg::ACT_BACKGROUND: issue = kind_seen != rtac_pkg::ACT_BACKGROUND;
            rtac_pkg::ACT_TRUE:       issue = kind_seen != rtac_pkg::ACT_TRUE
                                           || prev_rgb_reg != head.rgb;
            default:                  issue = kind_seen != rtac_pkg::ACT_PALETTE
                                           || prev_index_reg != head.index;
        endcase

        prev_kind_next  = kind_seen;
        prev_index_next = prev_index_reg;
        prev_rgb_next   = prev_rgb_reg;
        if (issue)
        begin
            prev_kind_next = head.kind;
            if (head.kind == rtac_pkg::ACT_TRUE)
                prev_rgb_next = head.rgb;
            if (head.kind == rtac_pkg::ACT_PALETTE)
                prev_index_next = head.index;
        end
        // The attribute reset at frame end invalidates the remembered colour
        if (head.last)
            prev_kind_next = rtac_pkg::ACT_NONE;

        out_next.home_cursor   = head.first;
        out_next.colour_action = issue ? head.kind : rtac_pkg::ACT_NONE;
        out_next.palette_index = (issue && head.kind == rtac_pkg::ACT_PALETTE) ? head.index
                                                                               : 8'd0;
        {out_next.true_red, out_next.true_green, out_next.true_blue} =
            (issue && head.kind == rtac_pkg::ACT_TRUE) ? head.rgb : 24'd0;
        out_next.glyph         = (cell_glyph == 8'd0) ? rtac_pkg::GLYPH_SPACE : cell_glyph;
        if (head.last)
            out_next.row_ending = rtac_pkg::END_ATTR_RESET;
        else if (head.row_last)
            out_next.row_ending = rtac_pkg::END_CRLF;
        else
            out_next.row_ending = rtac_pkg::END_NONE;
        out_next.frame_done    = head.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_kind_reg  <= rtac_pkg::ACT_NONE;
            prev_index_reg <= 8'd0;
            prev_rgb_reg   <= 24'd0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                prev_kind_reg  <= prev_kind_next;
                prev_index_reg <= prev_index_next;
                prev_rgb_reg   <= prev_rgb_next;
            end
            else if (!cmd_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= out_next;
    end

    assign cmd_valid = out_valid_reg;
    assign cmd       = out_reg;

    `RTAC_ASSERT_NEXT(a_bk_frame_end_forgets, clk, rst_n, pop && head.last, prev_kind_reg == rtac_pkg::ACT_NONE)
    `RTAC_ASSERT_NEXT(a_bk_frame_start_issues, clk, rst_n, pop && head.first, out_reg.colour_action != rtac_pkg::ACT_NONE)
    `RTAC_ASSERT_NEXT(a_bk_issue_remembered, clk, rst_n, pop && issue, prev_kind_reg == $past(head.kind) || $past(head.last))

endmodule

`default_nettype wire

/* src/rgb_to_ansi_color_stream.sv */
// Top level of the RGB to terminal colour quantiser: config registers and
// the front, queue and back ends. Depends on rtac_pkg and the rtac_* modules.
//
//  Channel | Signals                          | Direction | Moves
//  --------+----------------------------------+-----------+---------------------------
//  pixel   | px_valid, px_stall, px           | in        | one cell per transaction
//  command | cmd_valid, cmd_stall, cmd        | out       | one result per transaction
//  config  | psel, penable, pwrite, paddr ... | in/out    | register write or read
//
// cmd_valid rises once a cell has passed the front stages, the queue entry and the output
// register; one cell per cycle is sustained while the command side takes results.
// The front keeps QUEUE_DEPTH slots in credit: its two stages plus the queue.
// px_stall rises when that credit is used up; cmd_stall holds the output
// register and backs the queue up. Reset clears the queue, the stage valids,
// the remembered colour and both registers; no clearing pass is needed.
`default_nettype none

module rgb_to_ansi_color_stream #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            px_valid,
    output logic                 px_stall,
    input  wire rtac_pkg::px_t   px,
    output logic                 cmd_valid,
    input  wire logic            cmd_stall,
    output rtac_pkg::cmd_t       cmd,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]        render_mode_reg;
    logic [7:0]        cell_glyph_reg;
    logic              push, pop, nonempty;
    rtac_pkg::cls_t    push_data, head;
    logic [CNT_W-1:0]  count;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            render_mode_reg <= rtac_pkg::MODE_PALETTE;
            cell_glyph_reg  <= 8'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                rtac_pkg::REG_RENDER_MODE: render_mode_reg <= pwdata[1:0];
                rtac_pkg::REG_CELL_GLYPH:  cell_glyph_reg  <= pwdata[7:0];
                default:                   render_mode_reg <= render_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rtac_pkg::REG_RENDER_MODE: prdata = {30'd0, render_mode_reg};
            rtac_pkg::REG_CELL_GLYPH:  prdata = {24'd0, cell_glyph_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    rtac_front #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .px_valid  (px_valid),
        .px_stall  (px_stall),
        .px        (px),
        .mode      (render_mode_reg),
        .count     (count),
        .push      (push),
        .push_data (push_data)
    );

    rtac_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .nonempty  (nonempty),
        .count     (count)
    );

    rtac_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .nonempty   (nonempty),
        .pop        (pop),
        .cell_glyph (cell_glyph_reg),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd)
    );

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for rgb_to_ansi_color_stream: streams cells through the pixel port,
// predicts each colour command (or takes a directed one) and compares it field by field on the command port.
// Depends on rtac_pkg and the RTL of the block; nothing else.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Render mode code left unused by the block; behaves as palette
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_CELLS = 103;
    localparam logic [1:0] PHASE_MODES [8] = '{rtac_pkg::MODE_PALETTE, rtac_pkg::MODE_GRAY,
                                               rtac_pkg::MODE_TRUE, MODE_SPARE,
                                               rtac_pkg::MODE_TRUE, rtac_pkg::MODE_PALETTE,
                                               rtac_pkg::MODE_GRAY, rtac_pkg::MODE_PALETTE};

    typedef struct {
        logic [1:0]     mode;
        logic [7:0]     glyph_sel;
        rtac_pkg::px_t  pix;
        bit             typed;
        rtac_pkg::cmd_t golden;
    } dir_row_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           px_valid = 1'b0;
    logic           px_stall;
    rtac_pkg::px_t  px = '0;
    logic           cmd_valid;
    logic           cmd_stall = 1'b0;
    rtac_pkg::cmd_t cmd;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    rtac_pkg::cmd_t pending_cmds[$];
    dir_row_t       rows[$];
    int             mismatches = 0;
    int             cells_sent = 0;
    int             cmds_seen = 0;
    bit             steady = 1'b0;
    logic [23:0]    recent_rgb = '0;

    // Shadow of the block's registers and remembered colour
    logic [1:0]  cfg_mode = rtac_pkg::MODE_PALETTE;
    logic [7:0]  cfg_glyph = '0;
    logic [1:0]  last_kind = rtac_pkg::ACT_NONE;
    logic [7:0]  last_index = '0;
    logic [23:0] last_rgb = '0;

    rgb_to_ansi_color_stream i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .px_valid  (px_valid),
        .px_stall  (px_stall),
        .px        (px),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int ramp_index(input int v);
        if (v < 8)
            return 16;
        if (v >= 248)
            return 231;
        return 232 + (v - 8) / 10;
    endfunction

    function automatic int blend8(input int p, input int o, input int a);
        return (o * a + p * (255 - a)) / 255;
    endfunction

    function automatic int cube_index(input int r, input int g, input int b);
        int r5, g5, b5, r8, g8, b8;
        r5 = r >> 3;
        g5 = g >> 3;
        b5 = b >> 3;
        r8 = r5 * 255 / 31;
        g8 = g5 * 255 / 31;
        b8 = b5 * 255 / 31;
        if (r5 == g5 && g5 == b5)
            return ramp_index(r8);
        return 16 + 36 * (r8 * 5 / 255) + 6 * (g8 * 5 / 255) + b8 * 5 / 255;
    endfunction

    function automatic int luma_index(input int r, input int g, input int b);
        return ramp_index((77 * r + 150 * g + 29 * b) >> 8);
    endfunction

    // Works out the command for one cell and advances the remembered colour
    function automatic rtac_pkg::cmd_t predict_command(input rtac_pkg::px_t c);
        rtac_pkg::cmd_t o;
        int             r, g, b, idx;
        logic [23:0]    rgb;
        o = '0;
        r = c.pixel_red;
        g = c.pixel_green;
        b = c.pixel_blue;
        if (c.frame_first)
            last_kind = rtac_pkg::ACT_NONE;
        if (c.overlay_present && c.overlay_alpha != 0)
        begin
            r = blend8(r, c.overlay_red, c.overlay_alpha);
            g = blend8(g, c.overlay_green, c.overlay_alpha);
            b = blend8(b, c.overlay_blue, c.overlay_alpha);
        end
        rgb = {r[7:0], g[7:0], b[7:0]};
        if (rgb == '0)
        begin
            if (last_kind != rtac_pkg::ACT_BACKGROUND)
            begin
                o.colour_action = rtac_pkg::ACT_BACKGROUND;
                last_kind = rtac_pkg::ACT_BACKGROUND;
            end
        end
        else if (cfg_mode == rtac_pkg::MODE_TRUE)
        begin
            if (last_kind != rtac_pkg::ACT_TRUE || last_rgb != rgb)
            begin
                o.colour_action = rtac_pkg::ACT_TRUE;
                {o.true_red, o.true_green, o.true_blue} = rgb;
                last_kind = rtac_pkg::ACT_TRUE;
                last_rgb = rgb;
            end
        end
        else
        begin
            idx = (cfg_mode == rtac_pkg::MODE_GRAY) ? luma_index(r, g, b)
                                                    : cube_index(r, g, b);
            if (last_kind != rtac_pkg::ACT_PALETTE || last_index != idx[7:0])
            begin
                o.colour_action = rtac_pkg::ACT_PALETTE;
                o.palette_index = idx[7:0];
                last_kind = rtac_pkg::ACT_PALETTE;
                last_index = idx[7:0];
            end
        end
        o.home_cursor = c.frame_first;
        o.glyph = (cfg_glyph == '0) ? rtac_pkg::GLYPH_SPACE : cfg_glyph;
        o.row_ending = c.frame_last ? rtac_pkg::END_ATTR_RESET
                                    : (c.row_last ? rtac_pkg::END_CRLF : rtac_pkg::END_NONE);
        o.frame_done = c.frame_last;
        // attribute reset at frame end forgets the colour
        if (c.frame_last)
            last_kind = rtac_pkg::ACT_NONE;
        return o;
    endfunction

    function automatic rtac_pkg::px_t mk_cell(input int pr, input int pg, input int pb,
                                              input bit ovp, input int oa, input int ovr,
                                              input int ovg, input int ovb, input bit first,
                                              input bit rowl, input bit last);
        rtac_pkg::px_t c;
        c.pixel_red = pr[7:0];
        c.pixel_green = pg[7:0];
        c.pixel_blue = pb[7:0];
        c.overlay_present = ovp;
        c.overlay_alpha = oa[7:0];
        c.overlay_red = ovr[7:0];
        c.overlay_green = ovg[7:0];
        c.overlay_blue = ovb[7:0];
        c.frame_first = first;
        c.row_last = rowl;
        c.frame_last = last;
        return c;
    endfunction

    function automatic rtac_pkg::cmd_t mk_cmd(input bit home, input logic [1:0] act,
                                              input int idx, input int red, input int green,
                                              input int blue, input int gl,
                                              input logic [1:0] ending, input bit done);
        rtac_pkg::cmd_t o;
        o.home_cursor = home;
        o.colour_action = act;
        o.palette_index = idx[7:0];
        o.true_red = red[7:0];
        o.true_green = green[7:0];
        o.true_blue = blue[7:0];
        o.glyph = gl[7:0];
        o.row_ending = ending;
        o.frame_done = done;
        return o;
    endfunction

    function automatic logic [7:0] extreme_level();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd7;
            2: return 8'd8;
            3: return 8'd247;
            4: return 8'd248;
            default: return 8'd255;
        endcase
    endfunction

    function automatic rtac_pkg::px_t rand_cell(input bit first, input bit rowl, input bit last);
        rtac_pkg::px_t c;
        int            pick;
        logic [7:0]    level;
        c = mk_cell($urandom, $urandom, $urandom, $urandom_range(99) < 20, $urandom,
                    $urandom, $urandom, $urandom, first, rowl, last);
        pick = $urandom_range(99);
        if (c.overlay_present)
        begin
            if (pick < 20)
                c.overlay_alpha = 8'd0;
            else if (pick < 40)
                c.overlay_alpha = rtac_pkg::FULL_ALPHA;
        end
        pick = $urandom_range(99);
        level = 8'($urandom);
        // repeats and flat areas are what let the no-change path fire
        if (pick < 25)
            {c.pixel_red, c.pixel_green, c.pixel_blue} = recent_rgb;
        else if (pick < 35)
            {c.pixel_red, c.pixel_green, c.pixel_blue} = '0;
        else if (pick < 45)
            {c.pixel_red, c.pixel_green, c.pixel_blue} = {level, level, level};
        else if (pick < 60)
            {c.pixel_red, c.pixel_green, c.pixel_blue} =
                {extreme_level(), extreme_level(), extreme_level()};
        recent_rgb = {c.pixel_red, c.pixel_green, c.pixel_blue};
        return c;
    endfunction

    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_command(input rtac_pkg::cmd_t got);
        rtac_pkg::cmd_t want;
        cmds_seen++;
        if (pending_cmds.size() == 0)
        begin
            $error("command transaction with no cell outstanding");
            mismatches++;
            return;
        end
        want = pending_cmds.pop_front();
        check_field("home_cursor", 8'(want.home_cursor), 8'(got.home_cursor));
        check_field("colour_action", 8'(want.colour_action), 8'(got.colour_action));
        check_field("palette_index", want.palette_index, got.palette_index);
        check_field("true_red", want.true_red, got.true_red);
        check_field("true_green", want.true_green, got.true_green);
        check_field("true_blue", want.true_blue, got.true_blue);
        check_field("glyph", want.glyph, got.glyph);
        check_field("row_ending", 8'(want.row_ending), 8'(got.row_ending));
        check_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
    endfunction

    // Command side: check accepted transactions, stall at random outside the steady phase
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
            check_command(cmd);
        if (steady)
            cmd_stall <= 1'b0;
        else
            cmd_stall <= ($urandom_range(99) < 38);
    end

    task automatic send_cell(input rtac_pkg::px_t c, input bit typed,
                             input rtac_pkg::cmd_t golden);
        int             gap;
        rtac_pkg::cmd_t predicted;
        gap = 0;
        while (!steady && $urandom_range(99) < 38)
            gap++;
        if (gap > 0)
        begin
            px_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        px <= c;
        px_valid <= 1'b1;
        @(posedge clk);
        while (px_stall)
            @(posedge clk);
        predicted = predict_command(c);
        pending_cmds = {pending_cmds, (typed ? golden : predicted)};
        cells_sent++;
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (sel == rtac_pkg::REG_RENDER_MODE)
            cfg_mode = value[1:0];
        else
            cfg_glyph = value[7:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Drain every outstanding command, then let the pipeline go quiet
    task automatic settle();
        px_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(input logic [1:0] mode, input logic [7:0] glyph_sel,
                           input rtac_pkg::px_t pix, input bit typed,
                           input rtac_pkg::cmd_t golden);
        rows = {rows, dir_row_t'{mode, glyph_sel, pix, typed, golden}};
    endtask

    task automatic stream_frames(input int budget);
        int sent, w, h, x, y;
        bit first, rowl, last;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(99) < 10)
            begin
                send_cell(rand_cell(1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1))),
                          1'b0, '0);
                sent++;
            end
            else
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 4);
                for (y = 0; y < h; y++)
                begin
                    for (x = 0; x < w; x++)
                    begin
                        first = (x == 0 && y == 0);
                        rowl = (x == w - 1);
                        last = rowl && (y == h - 1);
                        // occasionally break the frame structure
                        if ($urandom_range(99) < 3)
                            first = ~first;
                        if ($urandom_range(99) < 3)
                            last = ~last;
                        send_cell(rand_cell(first, rowl, last), 1'b0, '0);
                        sent++;
                    end
                end
            end
        end
    endtask

    initial
    begin
        logic [7:0] glyph_pick;

        // palette mode, default glyph
        add_row(rtac_pkg::MODE_PALETTE, 8'd0, mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b1,
                mk_cmd(1, rtac_pkg::ACT_BACKGROUND, 0, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0, mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_NONE, 0, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0,
                mk_cell(255, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_PALETTE, 231, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0,
                mk_cell(255, 255, 255, 0, 0, 0, 0, 0, 0, 1, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_NONE, 0, 0, 0, 0, 32, rtac_pkg::END_CRLF, 0));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0, mk_cell(255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_PALETTE, 196, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0, mk_cell(0, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_PALETTE, 21, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0, mk_cell(8, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b0, '0);
        add_row(rtac_pkg::MODE_PALETTE, 8'd0,
                mk_cell(240, 240, 240, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(rtac_pkg::MODE_PALETTE, 8'd0, mk_cell(0, 0, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_PALETTE, 16, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        // overlay with zero alpha leaves the pixel alone; then full alpha, no overlay, a blend
        add_row(rtac_pkg::MODE_PALETTE, 8'd0,
                mk_cell(0, 0, 0, 1, 0, 255, 255, 255, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_BACKGROUND, 0, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0,
                mk_cell(0, 0, 0, 1, 255, 255, 255, 255, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_PALETTE, 231, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0,
                mk_cell(0, 0, 0, 0, 255, 255, 255, 255, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_BACKGROUND, 0, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0,
                mk_cell(10, 200, 30, 1, 128, 250, 5, 90, 0, 0, 0), 1'b0, '0);
        add_row(rtac_pkg::MODE_PALETTE, 8'd0,
                mk_cell(100, 50, 25, 0, 0, 0, 0, 0, 0, 1, 1), 1'b0, '0);
        // gray ramp, top and bottom of the luma range
        add_row(rtac_pkg::MODE_GRAY, 8'd255, mk_cell(255, 255, 255, 0, 0, 0, 0, 0, 1, 0, 0),
                1'b1,
                mk_cmd(1, rtac_pkg::ACT_PALETTE, 231, 0, 0, 0, 255, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_GRAY, 8'd255, mk_cell(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_PALETTE, 16, 0, 0, 0, 255, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_GRAY, 8'd255, mk_cell(248, 248, 248, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b1,
                mk_cmd(0, rtac_pkg::ACT_PALETTE, 231, 0, 0, 0, 255, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_GRAY, 8'd255, mk_cell(247, 247, 247, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b0, '0);
        add_row(rtac_pkg::MODE_GRAY, 8'd255, mk_cell(8, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b0, '0);
        // true colour
        add_row(rtac_pkg::MODE_TRUE, 8'd65, mk_cell(255, 255, 255, 0, 0, 0, 0, 0, 1, 0, 0),
                1'b1,
                mk_cmd(1, rtac_pkg::ACT_TRUE, 0, 255, 255, 255, 65, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_TRUE, 8'd65, mk_cell(255, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b1,
                mk_cmd(0, rtac_pkg::ACT_NONE, 0, 0, 0, 0, 65, rtac_pkg::END_NONE, 0));
        add_row(rtac_pkg::MODE_TRUE, 8'd65, mk_cell(1, 2, 3, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_TRUE, 0, 1, 2, 3, 65, rtac_pkg::END_NONE, 0));
        // spare mode acts as palette; mode change mid-frame, then frame end
        add_row(MODE_SPARE, 8'd0, mk_cell(255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_PALETTE, 196, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));
        add_row(MODE_SPARE, 8'd0, mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_BACKGROUND, 0, 0, 0, 0, 32,
                       rtac_pkg::END_ATTR_RESET, 1));
        add_row(rtac_pkg::MODE_PALETTE, 8'd0, mk_cell(255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_cmd(0, rtac_pkg::ACT_PALETTE, 196, 0, 0, 0, 32, rtac_pkg::END_NONE, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].mode != cfg_mode || rows[i].glyph_sel != cfg_glyph)
            begin
                settle();
                write_reg(rtac_pkg::REG_RENDER_MODE, 32'(rows[i].mode));
                write_reg(rtac_pkg::REG_CELL_GLYPH, 32'(rows[i].glyph_sel));
            end
            send_cell(rows[i].pix, rows[i].typed, rows[i].golden);
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            case (phase % 3)
                0: glyph_pick = 8'd0;
                1: glyph_pick = 8'd255;
                default: glyph_pick = 8'($urandom_range(1, 254));
            endcase
            write_reg(rtac_pkg::REG_RENDER_MODE, 32'(PHASE_MODES[phase]));
            write_reg(rtac_pkg::REG_CELL_GLYPH, 32'(glyph_pick));
            // one phase runs flat out on both sides
            steady = (phase == 5);
            stream_frames(PHASE_CELLS);
        end
        steady = 1'b0;
        settle();

        $display("tb: %0d cells sent, %0d command transactions checked, %0d mismatches",
                 cells_sent, cmds_seen, mismatches);
        $display("tb: covered all render modes, glyph extremes, overlay blends, frame flags");
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule

/* rgb_to_ansi_color_stream.f */
+incdir+src
src/rtac_pkg.sv
src/rtac_front.sv
src/rtac_queue.sv
src/rtac_back.sv
src/rgb_to_ansi_color_stream.sv
verif/tb.sv
